[hw/rtl/c8_pkg.sv]
// Shared types, step codes and constants for the CHIP-8 core.
`timescale 1ns / 1ps
package c8_pkg;

    localparam int ADDR_W  = 12;
    localparam int LEVEL_W = 5;
    localparam int CNT_W   = 12;

    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] ADDR_LAST  = 12'hFFF;
    localparam logic [11:0] FONT_BYTES = 12'h050;
    localparam logic [15:0] OP_CLS     = 16'h00E0;
    localparam logic [15:0] OP_RET     = 16'h00EE;

    // item kinds
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_DISPRD  = 2'd2;
    localparam logic [1:0] CMD_EXEC    = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_UNK    = 2'd1;
    localparam logic [1:0] STAT_OVF    = 2'd2;
    localparam logic [1:0] STAT_UNF    = 2'd3;

    // instruction classes seen by the controller
    localparam logic [2:0] K_SIMPLE = 3'd0;
    localparam logic [2:0] K_FLAG   = 3'd1;
    localparam logic [2:0] K_CLS    = 3'd2;
    localparam logic [2:0] K_DRAW   = 3'd3;
    localparam logic [2:0] K_BCD    = 3'd4;
    localparam logic [2:0] K_STORE  = 3'd5;
    localparam logic [2:0] K_LOAD   = 3'd6;
    localparam logic [2:0] K_ERR    = 3'd7;

    // controller states, sent to the datapath as the step command
    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DISP     = 5'd2;
    localparam logic [4:0] ST_WAIT     = 5'd3;
    localparam logic [4:0] ST_FETCH_HI = 5'd4;
    localparam logic [4:0] ST_FETCH_LO = 5'd5;
    localparam logic [4:0] ST_REGRD    = 5'd6;
    localparam logic [4:0] ST_EXEC     = 5'd7;
    localparam logic [4:0] ST_CLS      = 5'd8;
    localparam logic [4:0] ST_DRAW_M   = 5'd9;
    localparam logic [4:0] ST_DRAW_A   = 5'd10;
    localparam logic [4:0] ST_DRAW_B   = 5'd11;
    localparam logic [4:0] ST_FLAG     = 5'd12;
    localparam logic [4:0] ST_BCD      = 5'd13;
    localparam logic [4:0] ST_STORE_RD = 5'd14;
    localparam logic [4:0] ST_STORE_WR = 5'd15;
    localparam logic [4:0] ST_LOAD_RD  = 5'd16;
    localparam logic [4:0] ST_LOAD_WR  = 5'd17;
    localparam logic [4:0] ST_DONE     = 5'd18;

    typedef struct packed {
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] item_cmd;
        logic [2:0] kind;
        logic       loop_end;
        logic       out_busy;
    } dp_stat_t;

    localparam logic [7:0] FONT [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

[hw/rtl/chip8_interpreter_core_unit.sv]
// Top level of the CHIP-8 interpreter core: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Steps: writes go from dispatch to done, reads add a wait state; execute fetches
//   both opcode bytes, reads registers and executes; draw loops per sprite row, flag
//   ops write VF, BCD writes digits, block moves loop per register, CLS sweeps the display.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: async active low; a sweep over the whole memory then loads the font, zeroes
//   memory, the display and V0..VF, with no item accepted until it finishes.
module chip8_interpreter_core_unit
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address, write_byte, key_states, random_byte
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, program_counter, read_data,
                                   // display_changed, sound_active
);

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    logic [1:0]  status;
    logic [11:0] pc;
    logic [7:0]  rdata;
    logic        changed;
    logic        sound;

    // controller steps the datapath one micro-operation per cycle unless stalled
    c8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (dstat),
        .cmd      (dcmd)
    );

    c8_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dcmd),
        .stat           (dstat),
        .in_valid       (s_tvalid),
        .in_cmd         (s_tuser),
        .in_address     (s_tdata[11:0]),
        .in_write_byte  (s_tdata[19:12]),
        .in_key_states  (s_tdata[35:20]),
        .in_random_byte (s_tdata[43:36]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (status),
        .out_pc         (pc),
        .out_read_data  (rdata),
        .out_changed    (changed),
        .out_sound      (sound)
    );

    assign m_tdata = {sound, changed, rdata, pc, status};

endmodule

[hw/rtl/c8_ctrl.sv]
// Sequencing state machine of the CHIP-8 core.
`timescale 1ns / 1ps
module c8_ctrl
    import c8_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign cmd.step = state_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (stat.loop_end) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid) state_next = ST_DISP;
            ST_DISP:
            begin
                unique case (stat.item_cmd)
                    CMD_WRITE:  state_next = ST_DONE;
                    CMD_READ:   state_next = ST_WAIT;
                    CMD_DISPRD: state_next = ST_WAIT;
                    default:    state_next = ST_FETCH_HI;
                endcase
            end
            ST_WAIT:     state_next = ST_DONE;
            ST_FETCH_HI: state_next = ST_FETCH_LO;
            ST_FETCH_LO: state_next = ST_REGRD;
            ST_REGRD:    state_next = ST_EXEC;
            ST_EXEC:
            begin
                unique case (stat.kind)
                    K_FLAG:  state_next = ST_FLAG;
                    K_CLS:   state_next = ST_CLS;
                    K_DRAW:  state_next = ST_DRAW_M;
                    K_BCD:   state_next = ST_BCD;
                    K_STORE: state_next = ST_STORE_RD;
                    K_LOAD:  state_next = ST_LOAD_RD;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CLS:      if (stat.loop_end) state_next = ST_DONE;
            ST_DRAW_M:   state_next = stat.loop_end ? ST_FLAG : ST_DRAW_A;
            ST_DRAW_A:   state_next = ST_DRAW_B;
            ST_DRAW_B:   state_next = ST_DRAW_M;
            ST_FLAG:     state_next = ST_DONE;
            ST_BCD:      if (stat.loop_end) state_next = ST_DONE;
            ST_STORE_RD: state_next = ST_STORE_WR;
            ST_STORE_WR: state_next = stat.loop_end ? ST_DONE : ST_STORE_RD;
            ST_LOAD_RD:  state_next = ST_LOAD_WR;
            ST_LOAD_WR:  state_next = stat.loop_end ? ST_DONE : ST_LOAD_RD;
            ST_DONE:     if (!stat.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/c8_dp.sv]
// Datapath of the CHIP-8 core: memories, registers, ALU and result register.
`timescale 1ns / 1ps
module c8_dp
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        in_valid,
    input  logic [1:0]  in_cmd,
    input  logic [11:0] in_address,
    input  logic [7:0]  in_write_byte,
    input  logic [15:0] in_key_states,
    input  logic [7:0]  in_random_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic [11:0] out_pc,
    output logic [7:0]  out_read_data,
    output logic        out_changed,
    output logic        out_sound
);

    localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]  mem [4096];
    logic [7:0]  disp [256];
    logic [7:0]  vreg [16];
    logic [11:0] stack [STACK_DEPTH];

    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic [7:0]  wbyte_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;

    logic [11:0] pc_reg, pc_next;
    logic [11:0] i_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [7:0]  delay_reg, sound_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0] op_reg;
    logic [7:0]  sprite_reg;
    logic        flag_reg;
    logic [7:0]  d_hund_reg, d_tens_reg, d_ones_reg;
    logic [1:0]  st_reg;
    logic [7:0]  rd_reg;
    logic        chg_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [11:0] out_pc_reg;
    logic [7:0]  out_rd_reg;
    logic        out_chg_reg;
    logic        out_snd_reg;

    logic [7:0]  mem_q, disp_q, rq_a, rq_b;
    logic [11:0] stk_q;

    logic [11:0] mem_raddr, mem_waddr;
    logic [7:0]  mem_wdata;
    logic        mem_we;
    logic [7:0]  disp_raddr, disp_waddr, disp_wdata;
    logic        disp_we;
    logic [3:0]  ra_addr, rb_addr, vw_addr;
    logic [7:0]  vw_data;
    logic        vw_en;

    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn, i_plus_cnt;
    logic [2:0]  kind;
    logic [1:0]  err_code;
    logic        last_step;
    logic        load_out;

    logic [7:0]  alu_val;
    logic        alu_flag, alu_wr, skip;
    logic [8:0]  sum9;
    logic [15:0] prod_t;
    logic [13:0] prod_h;
    logic [4:0]  tens;
    logic [1:0]  hund;
    logic [4:0]  py;
    logic [7:0]  row_a, row_b;
    logic [15:0] win_a, win_b;
    logic [SIW-1:0] pop_idx;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx  = rq_a;
    assign vy  = rq_b;
    assign i_plus_cnt = i_reg + cnt_reg;
    assign pop_idx = SIW'(level_reg - 1'b1);

    // sprite placement: row wraps at 32, the two bytes it straddles wrap at 64 pixels
    assign py    = 5'(vy[4:0] + cnt_reg[4:0]);
    assign row_a = {py, vx[5:3]};
    assign row_b = {py, 3'(vx[5:3] + 3'd1)};
    assign win_a = {mem_q, 8'h00} >> vx[2:0];
    assign win_b = {sprite_reg, 8'h00} >> vx[2:0];

    assign load_out = (cmd.step == ST_DONE) && !(out_valid_reg && !out_ready);

    assign stat.item_cmd = cmd_reg;
    assign stat.kind     = kind;
    assign stat.loop_end = last_step;
    assign stat.out_busy = out_valid_reg && !out_ready;

    // instruction class and error code
    always_comb
    begin
        kind     = K_SIMPLE;
        err_code = STAT_UNK;
        unique case (op_reg[15:12])
            4'h0:
            begin
                if (op_reg == OP_CLS)
                    kind = K_CLS;
                else if (op_reg == OP_RET)
                begin
                    err_code = STAT_UNF;
                    if (level_reg == '0) kind = K_ERR;
                end
                else
                    kind = K_ERR;
            end
            4'h2:
            begin
                err_code = STAT_OVF;
                if (level_reg == LEVEL_W'(STACK_DEPTH)) kind = K_ERR;
            end
            4'h5, 4'h9: if (n != 4'h0) kind = K_ERR;
            4'h8:
            begin
                unique case (n)
                    4'h0, 4'h1, 4'h2, 4'h3: kind = K_SIMPLE;
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE: kind = K_FLAG;
                    default: kind = K_ERR;
                endcase
            end
            4'hD: kind = K_DRAW;
            4'hE: if (nn != 8'h9E && nn != 8'hA1) kind = K_ERR;
            4'hF:
            begin
                unique case (nn)
                    8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: kind = K_SIMPLE;
                    8'h33:   kind = K_BCD;
                    8'h55:   kind = K_STORE;
                    8'h65:   kind = K_LOAD;
                    default: kind = K_ERR;
                endcase
            end
            default: kind = K_SIMPLE;
        endcase
    end

    // register results, flag and next PC of an executed instruction
    always_comb
    begin
        alu_val  = 8'h00;
        alu_flag = 1'b0;
        alu_wr   = 1'b0;
        skip     = 1'b0;
        sum9     = {1'b0, vx} + {1'b0, vy};
        pc_next  = pc_reg + 12'd2;
        unique case (op_reg[15:12])
            4'h0: if (op_reg == OP_RET) pc_next = stk_q + 12'd2;
            4'h1, 4'h2: pc_next = nnn;
            4'h3: skip = (vx == nn);
            4'h4: skip = (vx != nn);
            4'h5: skip = (vx == vy);
            4'h6: begin alu_wr = 1'b1; alu_val = nn; end
            4'h7: begin alu_wr = 1'b1; alu_val = vx + nn; end
            4'h8:
            begin
                alu_wr = 1'b1;
                unique case (n)
                    4'h0: alu_val = vy;
                    4'h1: alu_val = vx | vy;
                    4'h2: alu_val = vx & vy;
                    4'h3: alu_val = vx ^ vy;
                    4'h4: begin alu_val = sum9[7:0]; alu_flag = sum9[8]; end
                    4'h5: begin alu_val = vx - vy; alu_flag = (vx >= vy); end
                    4'h6: begin alu_val = vx >> 1; alu_flag = vx[0]; end
                    4'h7: begin alu_val = vy - vx; alu_flag = (vy >= vx); end
                    4'hE: begin alu_val = vx << 1; alu_flag = vx[7]; end
                    default: alu_wr = 1'b0;
                endcase
            end
            4'h9: skip = (vx != vy);
            4'hB: pc_next = nnn + {4'h0, vy};
            4'hC: begin alu_wr = 1'b1; alu_val = rnd_reg & nn; end
            4'hE:
            begin
                if (nn == 8'h9E) skip = keys_reg[vx[3:0]];
                else skip = !keys_reg[vx[3:0]];
            end
            4'hF:
            begin
                if (nn == 8'h07)
                begin
                    alu_wr  = 1'b1;
                    alu_val = delay_reg;
                end
            end
            default: alu_wr = 1'b0;
        endcase
        if (skip) pc_next = pc_reg + 12'd4;
    end

    // decimal digits of VX by reciprocal multiplication
    assign prod_t = vx * 8'd205;
    assign prod_h = vx * 6'd41;
    assign tens   = prod_t[15:11];
    assign hund   = prod_h[13:12];

    always_comb
    begin
        unique case (cmd.step)
            ST_CLEAR:    last_step = (cnt_reg == ADDR_LAST);
            ST_CLS:      last_step = (cnt_reg[7:0] == 8'hFF);
            ST_BCD:      last_step = (cnt_reg[1:0] == 2'd2);
            ST_DRAW_M:   last_step = (cnt_reg[3:0] == n);
            ST_STORE_WR,
            ST_LOAD_WR:  last_step = (cnt_reg[3:0] == x);
            default:     last_step = 1'b0;
        endcase
    end

    // memory and register file port selection
    always_comb
    begin
        mem_raddr  = pc_reg;
        mem_waddr  = i_plus_cnt;
        mem_wdata  = 8'h00;
        mem_we     = 1'b0;
        disp_raddr = row_a;
        disp_waddr = cnt_reg[7:0];
        disp_wdata = 8'h00;
        disp_we    = 1'b0;
        ra_addr    = x;
        rb_addr    = (op_reg[15:12] == 4'hB) ? 4'h0 : y;
        vw_addr    = x;
        vw_data    = alu_val;
        vw_en      = 1'b0;
        unique case (cmd.step)
            ST_CLEAR:
            begin
                mem_waddr = cnt_reg;
                mem_wdata = (cnt_reg < FONT_BYTES) ? FONT[cnt_reg[6:0]] : 8'h00;
                mem_we    = 1'b1;
                disp_we   = 1'b1;
                vw_addr   = cnt_reg[3:0];
                vw_data   = 8'h00;
                vw_en     = 1'b1;
            end
            ST_DISP:
            begin
                mem_raddr  = (cmd_reg == CMD_EXEC) ? pc_reg : addr_reg;
                mem_waddr  = addr_reg;
                mem_wdata  = wbyte_reg;
                mem_we     = (cmd_reg == CMD_WRITE);
                disp_raddr = addr_reg[7:0];
            end
            ST_FETCH_HI: mem_raddr = pc_reg + 12'd1;
            ST_EXEC:     vw_en = (kind != K_ERR) && alu_wr;
            ST_CLS:      disp_we = 1'b1;
            ST_DRAW_M:   mem_raddr = i_plus_cnt;
            ST_DRAW_A:
            begin
                disp_waddr = row_a;
                disp_wdata = disp_q ^ win_a[15:8];
                disp_we    = 1'b1;
                disp_raddr = row_b;
            end
            ST_DRAW_B:
            begin
                disp_waddr = row_b;
                disp_wdata = disp_q ^ win_b[7:0];
                disp_we    = 1'b1;
            end
            ST_FLAG:
            begin
                vw_addr = 4'hF;
                vw_data = {7'd0, flag_reg};
                vw_en   = 1'b1;
            end
            ST_BCD:
            begin
                mem_we = 1'b1;
                unique case (cnt_reg[1:0])
                    2'd0:    mem_wdata = d_hund_reg;
                    2'd1:    mem_wdata = d_tens_reg;
                    default: mem_wdata = d_ones_reg;
                endcase
            end
            ST_STORE_RD: ra_addr = cnt_reg[3:0];
            ST_STORE_WR:
            begin
                mem_wdata = rq_a;
                mem_we    = 1'b1;
            end
            ST_LOAD_RD:  mem_raddr = i_plus_cnt;
            ST_LOAD_WR:
            begin
                vw_addr = cnt_reg[3:0];
                vw_data = mem_q;
                vw_en   = 1'b1;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (disp_we) disp[disp_waddr] <= disp_wdata;
        disp_q <= disp[disp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vw_en) vreg[vw_addr] <= vw_data;
        if (cmd.step == ST_REGRD || cmd.step == ST_STORE_RD) rq_a <= vreg[ra_addr];
        if (cmd.step == ST_REGRD) rq_b <= vreg[rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == ST_EXEC && kind == K_SIMPLE && op_reg[15:12] == 4'h2)
            stack[level_reg[SIW-1:0]] <= pc_reg;
        if (cmd.step == ST_REGRD) stk_q <= stack[pop_idx];
    end

    // payload, opcode, sprite, digit and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.step == ST_IDLE && in_valid)
        begin
            cmd_reg   <= in_cmd;
            addr_reg  <= in_address;
            wbyte_reg <= in_write_byte;
            keys_reg  <= in_key_states;
            rnd_reg   <= in_random_byte;
        end
        if (cmd.step == ST_FETCH_HI) op_reg[15:8] <= mem_q;
        if (cmd.step == ST_FETCH_LO) op_reg[7:0] <= mem_q;
        if (cmd.step == ST_DRAW_A) sprite_reg <= mem_q;
        if (cmd.step == ST_EXEC)
        begin
            d_hund_reg <= {6'd0, hund};
            d_tens_reg <= 8'(tens - 5'(hund * 4'd10));
            d_ones_reg <= vx - 8'(tens * 4'd10);
        end
        if (load_out)
        begin
            out_status_reg <= st_reg;
            out_pc_reg     <= pc_reg;
            out_rd_reg     <= rd_reg;
            out_chg_reg    <= chg_reg;
            out_snd_reg    <= (sound_reg != 8'h00);
        end
    end

    // architectural and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PROG_START;
            i_reg         <= '0;
            level_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            st_reg        <= STAT_OK;
            rd_reg        <= '0;
            chg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (cmd.step)
                ST_CLEAR, ST_CLS, ST_BCD, ST_DRAW_B, ST_STORE_WR, ST_LOAD_WR:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_EXEC: cnt_reg <= '0;
                default: cnt_reg <= cnt_reg;
            endcase

            if (cmd.step == ST_DISP)
            begin
                st_reg  <= STAT_OK;
                rd_reg  <= 8'h00;
                chg_reg <= 1'b0;
                if (cmd_reg == CMD_EXEC)
                begin
                    if (delay_reg != 8'h00) delay_reg <= delay_reg - 1'b1;
                    if (sound_reg != 8'h00) sound_reg <= sound_reg - 1'b1;
                end
            end

            if (cmd.step == ST_WAIT)
                rd_reg <= (cmd_reg == CMD_DISPRD) ? disp_q : mem_q;

            if (cmd.step == ST_DRAW_A && (disp_q & win_a[15:8]) != 8'h00) flag_reg <= 1'b1;
            if (cmd.step == ST_DRAW_B && (disp_q & win_b[7:0]) != 8'h00) flag_reg <= 1'b1;

            if (cmd.step == ST_EXEC)
            begin
                if (kind == K_ERR)
                    st_reg <= err_code;
                else
                begin
                    pc_reg   <= pc_next;
                    flag_reg <= alu_flag;
                    chg_reg  <= (kind == K_CLS) || (kind == K_DRAW);
                    if (op_reg == OP_RET) level_reg <= level_reg - 1'b1;
                    if (op_reg[15:12] == 4'h2) level_reg <= level_reg + 1'b1;
                    if (op_reg[15:12] == 4'hA) i_reg <= nnn;
                    if (op_reg[15:12] == 4'hF)
                    begin
                        unique case (nn)
                            8'h15:   delay_reg <= vx;
                            8'h18:   sound_reg <= vx;
                            8'h1E:   i_reg <= i_reg + {4'h0, vx};
                            8'h29:   i_reg <= 12'(vx[3:0] * 3'd5);
                            default: i_reg <= i_reg;
                        endcase
                    end
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_pc        = out_pc_reg;
    assign out_read_data = out_rd_reg;
    assign out_changed   = out_chg_reg;
    assign out_sound     = out_snd_reg;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");
    a_err_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == ST_EXEC && kind == K_ERR) |=> $stable(pc_reg))
        else $error("failed instruction moved the pc");
    a_idle_timers: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == ST_IDLE) |=> $stable(sound_reg) && $stable(delay_reg))
        else $error("timer moved while idle");
`endif

endmodule

[tb/chip8_core_checker.sv]
// Checker for the CHIP-8 core: tracks architectural state and compares every result item.
`timescale 1ns / 1ps
module chip8_core_checker
    import c8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    // first member lands in the top bits
    typedef struct packed {
        logic        sound;
        logic        changed;
        logic [7:0]  rdata;
        logic [11:0] pc;
        logic [1:0]  status;
    } core_result_t;

    logic [7:0]  mem [0:4095];
    logic        pix [0:2047];
    logic [7:0]  v [0:15];
    logic [11:0] idx;
    logic [11:0] pc;
    logic [11:0] rstack [0:15];
    logic [4:0]  level;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    core_result_t expected_q [$];

    initial
    begin
        for (int a = 0; a < 4096; a++)
            mem[a] = (a < 80) ? FONT[a] : 8'h00;
        for (int a = 0; a < 2048; a++)
            pix[a] = 1'b0;
        for (int a = 0; a < 16; a++)
            v[a] = 8'h00;
        idx = '0;
        pc = PROG_START;
        level = '0;
        delay_cnt = '0;
        sound_cnt = '0;
    end

    // runs one instruction; returns status, sets changed on clear/draw
    function automatic logic [1:0] run_instr(input logic [15:0] keys, input logic [7:0] rnd,
                                             output logic changed);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, row;
        logic [11:0] nnn, nxt;
        logic [8:0]  sum;
        logic        hit;
        int          k;
        op = {mem[pc], mem[pc + 12'd1]};
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        vx = v[x];
        vy = v[y];
        nxt = pc + 12'd2;
        changed = 1'b0;
        case (op[15:12])
            4'h0:
            begin
                if (op == OP_CLS)
                begin
                    for (int a = 0; a < 2048; a++)
                        pix[a] = 1'b0;
                    changed = 1'b1;
                end
                else if (op == OP_RET)
                begin
                    if (level == 0)
                        return STAT_UNF;
                    level = level - 5'd1;
                    nxt = rstack[level] + 12'd2;
                end
                else
                    return STAT_UNK;
            end
            4'h1: nxt = nnn;
            4'h2:
            begin
                if (level >= 16)
                    return STAT_OVF;
                rstack[level] = pc;
                level = level + 5'd1;
                nxt = nnn;
            end
            4'h3: if (vx == nn) nxt += 12'd2;
            4'h4: if (vx != nn) nxt += 12'd2;
            4'h5:
            begin
                if (n != 0)
                    return STAT_UNK;
                if (vx == vy) nxt += 12'd2;
            end
            4'h6: v[x] = nn;
            4'h7: v[x] = vx + nn;
            4'h8:
            begin
                case (n)
                    4'h0: v[x] = vy;
                    4'h1: v[x] = vx | vy;
                    4'h2: v[x] = vx & vy;
                    4'h3: v[x] = vx ^ vy;
                    4'h4:
                    begin
                        sum = vx + vy;
                        v[x] = sum[7:0];
                        v[15] = {7'd0, sum[8]};
                    end
                    4'h5:
                    begin
                        v[x] = vx - vy;
                        v[15] = {7'd0, vx >= vy};
                    end
                    4'h6:
                    begin
                        v[x] = vx >> 1;
                        v[15] = {7'd0, vx[0]};
                    end
                    4'h7:
                    begin
                        v[x] = vy - vx;
                        v[15] = {7'd0, vy >= vx};
                    end
                    4'hE:
                    begin
                        v[x] = vx << 1;
                        v[15] = {7'd0, vx[7]};
                    end
                    default: return STAT_UNK;
                endcase
            end
            4'h9:
            begin
                if (n != 0)
                    return STAT_UNK;
                if (vx != vy) nxt += 12'd2;
            end
            4'hA: idx = nnn;
            4'hB: nxt = nnn + {4'h0, v[0]};
            4'hC: v[x] = rnd & nn;
            4'hD:
            begin
                hit = 1'b0;
                for (int r = 0; r < n; r++)
                begin
                    row = mem[idx + r[11:0]];
                    for (int c = 0; c < 8; c++)
                    begin
                        if (row[7 - c])
                        begin
                            k = ((vy + r) % 32) * 64 + ((vx + c) % 64);
                            if (pix[k]) hit = 1'b1;
                            pix[k] = ~pix[k];
                        end
                    end
                end
                v[15] = {7'd0, hit};
                changed = 1'b1;
            end
            4'hE:
            begin
                if (nn == 8'h9E)
                begin
                    if (keys[vx[3:0]]) nxt += 12'd2;
                end
                else if (nn == 8'hA1)
                begin
                    if (!keys[vx[3:0]]) nxt += 12'd2;
                end
                else
                    return STAT_UNK;
            end
            default:
            begin
                case (nn)
                    8'h07: v[x] = delay_cnt;
                    8'h0A: ;
                    8'h15: delay_cnt = vx;
                    8'h18: sound_cnt = vx;
                    8'h1E: idx = idx + {4'h0, vx};
                    8'h29: idx = 12'(vx[3:0] * 4'd5);
                    8'h33:
                    begin
                        mem[idx] = vx / 8'd100;
                        mem[idx + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem[idx + 12'd2] = vx % 8'd10;
                    end
                    8'h55:
                        for (int i = 0; i <= x; i++)
                            mem[idx + i[11:0]] = v[i];
                    8'h65:
                        for (int i = 0; i <= x; i++)
                            v[i] = mem[idx + i[11:0]];
                    default: return STAT_UNK;
                endcase
            end
        endcase
        pc = nxt;
        return STAT_OK;
    endfunction

    // predicts the result item caused by one accepted input item
    function automatic core_result_t predict_result(input logic [1:0] cmd,
                                                    input logic [47:0] d);
        core_result_t res;
        logic [11:0]  addr;
        int           base;
        logic         chg;
        addr = d[11:0];
        res = '0;
        case (cmd)
            CMD_WRITE:  mem[addr] = d[19:12];
            CMD_READ:   res.rdata = mem[addr];
            CMD_DISPRD:
            begin
                base = addr[7:3] * 64 + addr[2:0] * 8;
                for (int k = 0; k < 8; k++)
                    res.rdata[7 - k] = pix[base + k];
            end
            default:
            begin
                if (delay_cnt != 0) delay_cnt--;
                if (sound_cnt != 0) sound_cnt--;
                res.status = run_instr(d[35:20], d[43:36], chg);
                res.changed = chg;
            end
        endcase
        res.pc = pc;
        res.sound = (sound_cnt != 0);
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        core_result_t got, want;
        if (!rst_n)
            fail_count = 0;
        if (rst_n && s_tvalid && s_tready)
            expected_q.push_back(predict_result(s_tuser, s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.pc !== want.pc ||
                    got.rdata !== want.rdata || got.changed !== want.changed ||
                    got.sound !== want.sound)
                begin
                    $display("%0t: expected st=%0d pc=%h rd=%h chg=%b snd=%b", $time,
                             want.status, want.pc, want.rdata, want.changed, want.sound);
                    $display("%0t: actual   st=%0d pc=%h rd=%h chg=%b snd=%b", $time,
                             got.status, got.pc, got.rdata, got.changed, got.sound);
                    fail_count++;
                end
            end
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the CHIP-8 core: stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module tb_top
    import c8_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          hold_off_req;
    bit          stim_done;
    int          burst_left;

    chip8_interpreter_core_unit DUT (.*);

    chip8_core_checker checker_i (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int hold;
        bit held;
        m_tready = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                m_tready <= 1'b0;
                held = 1'b1;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
            end
            else if (($time / 20000) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // send one item; idles between bursts
    task automatic send_item(input logic [1:0] cmd, input logic [11:0] addr,
                             input logic [7:0] wbyte, input logic [15:0] keys,
                             input logic [7:0] rnd);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'd0, rnd, keys, wbyte, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // send one item of the given kind with random fields
    task automatic send_rand(input logic [1:0] cmd);
        send_item(cmd, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // place one opcode at addr
    task automatic put_op(input logic [11:0] addr, input logic [15:0] op);
        send_item(CMD_WRITE, addr, op[15:8], 16'($urandom), 8'($urandom));
        send_item(CMD_WRITE, addr + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    endtask

    task automatic run_op(input logic [11:0] pcv, input logic [15:0] op);
        put_op(pcv, op);
        send_rand(CMD_EXEC);
    endtask

    // random opcode biased toward valid instructions
    function automatic logic [15:0] pick_op();
        logic [15:0] op;
        logic [7:0]  fx [0:9];
        fx = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
        op = 16'($urandom);
        case ($urandom_range(0, 15))
            0: op = $urandom_range(0, 1) ? OP_CLS : OP_RET;
            5, 9: op[3:0] = ($urandom_range(0, 7) == 0) ? op[3:0] : 4'h0;
            8: op[3:0] = ($urandom_range(0, 7) == 0) ? op[3:0] :
                         4'($urandom_range(0, 8) == 8 ? 14 : $urandom_range(0, 7));
            13: op[3:0] = 4'($urandom_range(0, 4));
            14: op[7:0] = ($urandom_range(0, 7) == 0) ? op[7:0] :
                          ($urandom_range(0, 1) ? 8'h9E : 8'hA1);
            15: op[7:0] = fx[$urandom_range(0, 9)];
            default: ;
        endcase
        if (op[15:12] == 4'hF && op[7:0] == 8'h00)
            op[7:0] = 8'($urandom);
        return op;
    endfunction

    function automatic logic [11:0] checker_pc();
        return checker_i.pc;
    endfunction

    initial
    begin
        int          execs;
        logic [15:0] op;
        logic [11:0] a;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_WRITE;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        burst_left = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: font, memory ends, display ends, field extremes
        send_item(CMD_READ, 12'h000, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_READ, 12'h04F, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(CMD_READ, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_item(CMD_DISPRD, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        run_op(12'h200, 16'h60FF);           // V0 = FF
        run_op(12'h202, 16'h6101);
        run_op(12'h204, 16'h8014);           // add with carry
        run_op(12'h206, 16'h8015);           // subtract, borrow
        run_op(12'h208, 16'h800E);           // shift left bit 7
        run_op(12'h20A, 16'hA000);
        run_op(12'h20C, 16'hD01F);           // draw at column 62, row 1, wrapping
        run_op(12'h20E, 16'hD01F);           // collision
        send_item(CMD_DISPRD, 12'h000, 8'h00, 16'h0000, 8'h00);
        run_op(12'h210, 16'h00EE);           // stack underflow
        run_op(12'h210, 16'h0123);           // unknown
        run_op(12'h210, 16'h2300);           // call
        run_op(12'h300, 16'h00EE);           // return to 0x212
        run_op(12'h212, 16'h00E0);
        run_op(12'h214, 16'hF033);           // BCD
        run_op(12'h216, 16'h6F3F);
        run_op(12'h218, 16'hDFF0);           // draw at the far corner, N zero
        run_op(12'h21A, 16'hFF18);           // sound timer
        run_op(12'h21C, 16'hBFFF);           // jump wraps address

        // random: mostly instruction writes and executes at the live PC
        execs = 0;
        while (execs < 540)
        begin
            if (execs == 200)
                hold_off_req = 1'b1;
            case ($urandom_range(0, 9))
                0: send_rand(CMD_WRITE);
                1: send_rand(CMD_READ);
                2: send_rand(CMD_DISPRD);
                default:
                begin
                    // write the op at the PC the checker predicts
                    a = checker_pc();
                    op = pick_op();
                    if (op[15:12] == 4'h0 && op == OP_RET && $urandom_range(0, 3) != 0)
                        op = 16'h2000 | 16'($urandom_range(0, 4095));
                    put_op(a, op);
                    send_rand(CMD_EXEC);
                    execs++;
                end
            endcase
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
